>>> rtl/core/ffpa_pkg.sv
package ffpa_pkg;

  localparam int MaxExtents = 16;
  localparam int PageBits   = 16;
  localparam int SizeBits   = PageBits + 1;
  localparam int IdxBits    = $clog2(MaxExtents);
  localparam int CntBits    = $clog2(MaxExtents + 1);

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_ALLOC = 2'd1;
  localparam logic [1:0] ACT_FREE  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  localparam logic [SizeBits-1:0] SizeMax = {SizeBits{1'b1}};

  // one table access issued by the sequencer
  typedef struct packed {
    logic                rd_en;
    logic [IdxBits-1:0]  rd_addr;
    logic                wr_en;
    logic [IdxBits-1:0]  wr_addr;
    logic [PageBits-1:0] wr_base;
    logic [SizeBits-1:0] wr_size;
  } tbl_req_t;

  typedef struct packed {
    logic [PageBits-1:0] base;
    logic [SizeBits-1:0] size;
  } tbl_rd_t;

endpackage

>>> rtl/core/ffpa_table.sv
module ffpa_table (
  input  logic              clk,
  input  ffpa_pkg::tbl_req_t req,
  output ffpa_pkg::tbl_rd_t  rd
);

  logic [ffpa_pkg::PageBits-1:0] base_mem [ffpa_pkg::MaxExtents];
  logic [ffpa_pkg::SizeBits-1:0] size_mem [ffpa_pkg::MaxExtents];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      base_mem[req.wr_addr] <= req.wr_base;
      size_mem[req.wr_addr] <= req.wr_size;
    end
    if (req.rd_en) begin
      rd.base <= base_mem[req.rd_addr];
      rd.size <= size_mem[req.rd_addr];
    end
  end

endmodule

>>> rtl/core/first_fit_page_allocator_unit.sv
// channel | dir | tdata (low bit up)                      | tuser
// in_     | in  | start_page[15:0], page_count[31:16]     | action[1:0]
// out_    | out | alloc_start[15:0], free_total[32:16]    | status[1:0]
//
// A request visits table entries by reading each one from the extent table,
// whose read is registered, then checking it; a shift walks the table one
// entry at a time. Allocate: scan up to the fitting entry, then shift if it
// empties. Free: scan to the slot, shift up, then merge (each merge a further
// shift). Add inserts like Free but does not merge. Reset empties the table
// at once. in_tready is low from acceptance until the result is taken.
module first_fit_page_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // start_page, page_count
  input  logic [1:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // alloc_start, free_total, zero pad
  output logic [1:0]  out_tuser   // status
);

  localparam int PB = ffpa_pkg::PageBits;
  localparam int SB = ffpa_pkg::SizeBits;
  localparam int IB = ffpa_pkg::IdxBits;
  localparam int CB = ffpa_pkg::CntBits;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRD   = 4'd1;  // scan: issue read
  localparam logic [3:0] S_SCHK  = 4'd2;  // scan: check
  localparam logic [3:0] S_RMRD  = 4'd3;  // remove: read i+1
  localparam logic [3:0] S_RMWR  = 4'd4;  // remove: write i
  localparam logic [3:0] S_INRD  = 4'd5;  // insert shift: read i-1
  localparam logic [3:0] S_INWR  = 4'd6;  // insert shift: write i
  localparam logic [3:0] S_PRD   = 4'd7;  // merge: read previous
  localparam logic [3:0] S_PCHK  = 4'd8;
  localparam logic [3:0] S_NRD   = 4'd9;  // merge: read next
  localparam logic [3:0] S_NCHK  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]    state_r, state_nxt;
  logic [1:0]    act_r, act_nxt;
  logic [PB-1:0] start_r, start_nxt;
  logic [PB-1:0] cnt_r, cnt_nxt;
  logic [CB-1:0] used_r, used_nxt;
  logic [SB-1:0] total_r, total_nxt;
  logic [CB-1:0] idx_r, idx_nxt;      // scan / shift pointer
  logic [CB-1:0] pos_r, pos_nxt;      // current extent position
  logic [PB-1:0] cb_r, cb_nxt;        // current extent base
  logic [SB-1:0] cs_r, cs_nxt;        // current extent size
  logic          merge_r, merge_nxt;  // after remove, go on to next merge
  logic [1:0]    st_r, st_nxt;
  logic [PB-1:0] grant_r, grant_nxt;

  ffpa_pkg::tbl_req_t req;
  ffpa_pkg::tbl_rd_t  rd;

  ffpa_table u_table (.clk(clk), .req(req), .rd(rd));

  logic [SB:0]   end_sum;
  logic [SB:0]   ssum;
  logic [SB-1:0] sat_sz;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {7'd0, total_r, grant_r};
  assign out_tuser  = st_r;

  always_comb begin
    state_nxt = state_r;  act_nxt = act_r;  start_nxt = start_r;  cnt_nxt = cnt_r;
    used_nxt = used_r;  total_nxt = total_r;  idx_nxt = idx_r;  pos_nxt = pos_r;
    cb_nxt = cb_r;  cs_nxt = cs_r;  merge_nxt = merge_r;  st_nxt = st_r;
    grant_nxt = grant_r;
    req = '0;
    end_sum = '0;
    ssum = '0;
    sat_sz = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt = in_tuser;
          start_nxt = in_tdata[15:0];
          cnt_nxt = in_tdata[31:16];
          st_nxt = ffpa_pkg::ST_OK;
          grant_nxt = '0;
          idx_nxt = '0;
          merge_nxt = 1'b0;
          state_nxt = S_OUT;
          if (in_tuser == ffpa_pkg::ACT_NONE) begin
            state_nxt = S_OUT;
          end else if (in_tdata[31:16] == '0) begin
            st_nxt = ffpa_pkg::ST_ZERO;
          end else if (in_tuser == ffpa_pkg::ACT_ALLOC) begin
            if ({1'b0, in_tdata[31:16]} > total_r) st_nxt = ffpa_pkg::ST_NOFIT;
            else state_nxt = S_SRD;
          end else if (used_r == CB'(ffpa_pkg::MaxExtents)) begin
            st_nxt = ffpa_pkg::ST_FULL;
          end else begin
            state_nxt = S_SRD;
          end
        end
      end
      S_SRD: begin
        if (idx_r >= used_r) begin
          if (act_r == ffpa_pkg::ACT_ALLOC) begin
            st_nxt = ffpa_pkg::ST_NOFIT;
            state_nxt = S_OUT;
          end else begin
            pos_nxt = idx_r;
            idx_nxt = used_r;
            state_nxt = S_INRD;
          end
        end else begin
          req.rd_en = 1'b1;
          req.rd_addr = idx_r[IB-1:0];
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if (act_r == ffpa_pkg::ACT_ALLOC) begin
          if (rd.size >= {1'b0, cnt_r}) begin
            grant_nxt = rd.base;
            total_nxt = total_r - {1'b0, cnt_r};
            if (rd.size > {1'b0, cnt_r}) begin
              req.wr_en = 1'b1;
              req.wr_addr = idx_r[IB-1:0];
              req.wr_base = rd.base + cnt_r;
              req.wr_size = rd.size - {1'b0, cnt_r};
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_RMRD;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
            state_nxt = S_SRD;
          end
        end else if (start_r < rd.base) begin
          pos_nxt = idx_r;
          idx_nxt = used_r;
          state_nxt = S_INRD;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_RMRD: begin
        if (idx_r + 1'b1 >= used_r) begin
          used_nxt = used_r - 1'b1;
          state_nxt = merge_r ? S_NRD : S_OUT;
        end else begin
          req.rd_en = 1'b1;
          req.rd_addr = IB'(idx_r + 1'b1);
          state_nxt = S_RMWR;
        end
      end
      S_RMWR: begin
        req.wr_en = 1'b1;
        req.wr_addr = idx_r[IB-1:0];
        req.wr_base = rd.base;
        req.wr_size = rd.size;
        idx_nxt = idx_r + 1'b1;
        state_nxt = S_RMRD;
      end
      S_INRD: begin
        if (idx_r == pos_r) begin
          req.wr_en = 1'b1;
          req.wr_addr = pos_r[IB-1:0];
          req.wr_base = start_r;
          req.wr_size = {1'b0, cnt_r};
          cb_nxt = start_r;
          cs_nxt = {1'b0, cnt_r};
          used_nxt = used_r + 1'b1;
          ssum = {1'b0, total_r} + {2'b0, cnt_r};
          total_nxt = ssum[SB] ? ffpa_pkg::SizeMax : ssum[SB-1:0];
          state_nxt = (act_r == ffpa_pkg::ACT_FREE) ? S_PRD : S_OUT;
        end else begin
          req.rd_en = 1'b1;
          req.rd_addr = IB'(idx_r - 1'b1);
          state_nxt = S_INWR;
        end
      end
      S_INWR: begin
        req.wr_en = 1'b1;
        req.wr_addr = idx_r[IB-1:0];
        req.wr_base = rd.base;
        req.wr_size = rd.size;
        idx_nxt = idx_r - 1'b1;
        state_nxt = S_INRD;
      end
      S_PRD: begin
        if (pos_r == '0) begin
          state_nxt = S_NRD;
        end else begin
          req.rd_en = 1'b1;
          req.rd_addr = IB'(pos_r - 1'b1);
          state_nxt = S_PCHK;
        end
      end
      S_PCHK: begin
        end_sum = {2'b0, rd.base} + {1'b0, rd.size};
        if (end_sum == {2'b0, cb_r}) begin
          ssum = {1'b0, rd.size} + {1'b0, cs_r};
          sat_sz = ssum[SB] ? ffpa_pkg::SizeMax : ssum[SB-1:0];
          req.wr_en = 1'b1;
          req.wr_addr = IB'(pos_r - 1'b1);
          req.wr_base = rd.base;
          req.wr_size = sat_sz;
          cb_nxt = rd.base;
          cs_nxt = sat_sz;
          idx_nxt = pos_r;
          pos_nxt = pos_r - 1'b1;
          merge_nxt = 1'b1;
          state_nxt = S_RMRD;
        end else begin
          state_nxt = S_NRD;
        end
      end
      S_NRD: begin
        if (pos_r + 1'b1 >= used_r) begin
          state_nxt = S_OUT;
        end else begin
          req.rd_en = 1'b1;
          req.rd_addr = IB'(pos_r + 1'b1);
          state_nxt = S_NCHK;
        end
      end
      S_NCHK: begin
        end_sum = {2'b0, cb_r} + {1'b0, cs_r};
        merge_nxt = 1'b0;
        if (end_sum == {2'b0, rd.base}) begin
          ssum = {1'b0, cs_r} + {1'b0, rd.size};
          sat_sz = ssum[SB] ? ffpa_pkg::SizeMax : ssum[SB-1:0];
          req.wr_en = 1'b1;
          req.wr_addr = pos_r[IB-1:0];
          req.wr_base = cb_r;
          req.wr_size = sat_sz;
          idx_nxt = pos_r + 1'b1;
          state_nxt = S_RMRD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      total_r <= '0;
      merge_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      total_r <= total_nxt;
      merge_r <= merge_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;  start_r <= start_nxt;  cnt_r <= cnt_nxt;
    idx_r <= idx_nxt;  pos_r <= pos_nxt;  cb_r <= cb_nxt;  cs_r <= cs_nxt;
    st_r <= st_nxt;  grant_r <= grant_nxt;
  end

`ifndef SYNTHESIS
  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CB'(ffpa_pkg::MaxExtents)) else $error("extent count overflow");
  a_idle_still: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !in_tvalid) |=> $stable(used_r) && $stable(total_r))
    else $error("state changed while idle");
  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ffpa_pkg::ST_OK) |-> out_tdata[15:0] == '0)
    else $error("grant on failed request");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(total_r))
    else $error("result dropped");
`endif

endmodule
